FILE: rtl/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

  // Matrix size and derived widths
  localparam int MATRIX_DIM = 4;
  localparam int NELEM      = MATRIX_DIM * MATRIX_DIM;
  localparam int K_W        = $clog2(MATRIX_DIM);
  localparam int ELEM_W     = $clog2(NELEM);
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + $clog2(MATRIX_DIM) + 1;
  localparam int IDX_W      = 4;
  localparam int FRAC_W     = 5;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);

  // Item mode codes
  localparam logic [1:0] MODE_WR_A    = 2'd0;
  localparam logic [1:0] MODE_WR_B    = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
    logic                     last;
  } out_item_t;

  // Control travelling with each operand pair into the MAC
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     saturated;
  } mac_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_OUT
  } mm4_state_t;

endpackage

`default_nettype wire

FILE: rtl/mm4_mac.sv
`default_nettype none

module mm4_mac import mm4_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [DATA_W-1:0] op_a,
  input  wire logic signed [DATA_W-1:0] op_b,
  input  wire logic [FRAC_W-1:0]        frac_bits,
  output mac_res_t                      res,
  output logic                          res_valid
);

  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 prod_ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     acc_done_r;
  logic signed [ACC_W-1:0]  sh_r;
  logic signed [ACC_W-1:0]  sh_nxt;
  logic                     sh_valid_r;
  mac_res_t                 res_r;
  mac_res_t                 res_nxt;
  logic                     res_valid_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic [ACC_W-DATA_W:0]    sh_top;

  assign prod_ext = $signed({{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r});

  always_comb begin
    acc_nxt = prod_ctl_r.first ? prod_ext : acc_r + prod_ext;
    // arithmetic shift floors towards minus infinity
    sh_nxt  = acc_r >>> frac_bits;
  end

  // In range when every bit above the result's sign bit matches it
  assign sh_top = sh_r[ACC_W-1:DATA_W-1];

  always_comb begin
    if ((&sh_top) || !(|sh_top)) begin
      res_nxt.value     = sh_r[DATA_W-1:0];
      res_nxt.saturated = 1'b0;
    end else begin
      res_nxt.value     = sh_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
      res_nxt.saturated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_ctl_r  <= '0;
      acc_done_r  <= 1'b0;
      sh_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      prod_ctl_r  <= ctl;
      acc_done_r  <= prod_ctl_r.valid && prod_ctl_r.last;
      sh_valid_r  <= acc_done_r;
      res_valid_r <= sh_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (prod_ctl_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (acc_done_r) begin
      sh_r <= sh_nxt;
    end
    if (sh_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

`default_nettype wire

FILE: rtl/matrix_multiply_4x4_core.sv
`default_nettype none

// Fixed-point 4x4 matrix multiplier. Write items (mode 0 for A, 1 for B) store one
// element each; mode 3 and out-of-range writes are dropped. A compute item (mode 2)
// emits the 16 elements of A*B in row-major order, the last one flagged. Each
// element is the exact dot product shifted right (floor) by fraction_bits and
// clamped to signed 32 bits, with saturated set when clamped. One multiplier walks
// the dot product a term per cycle, then a four-stage multiply, accumulate, shift
// and clamp pipe drains before the element is offered at the output; in_stall is
// high from the compute item until the last element is loaded for output. Both
// stores clear at reset and fraction_bits resets to 16. Write cfg only while idle.
module matrix_multiply_4x4_core import mm4_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [FRAC_W-1:0] cfg_wr_data
);

  mm4_state_t               state_r, state_nxt;
  logic [K_W-1:0]           row_r, row_nxt;
  logic [K_W-1:0]           col_r, col_nxt;
  logic [K_W-1:0]           k_r, k_nxt;
  logic [FRAC_W-1:0]        frac_r;
  logic [DATA_W-1:0]        a_store_r [NELEM];
  logic [DATA_W-1:0]        b_store_r [NELEM];
  logic signed [DATA_W-1:0] op_a_r, op_b_r;
  mac_ctl_t                 op_ctl_r, issue_ctl;
  mac_res_t                 mac_res;
  logic                     mac_res_valid;
  logic [ELEM_W-1:0]        a_addr, b_addr, out_pos;
  logic                     in_xfer, wr_ok;
  logic                     elem_last, out_free, out_load;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign wr_ok    = (32'(in_data.element_index) < NELEM);

  assign a_addr  = ELEM_W'(row_r) * ELEM_W'(MATRIX_DIM) + ELEM_W'(k_r);
  assign b_addr  = ELEM_W'(k_r) * ELEM_W'(MATRIX_DIM) + ELEM_W'(col_r);
  assign out_pos = ELEM_W'(row_r) * ELEM_W'(MATRIX_DIM) + ELEM_W'(col_r);

  assign elem_last = (row_r == K_W'(MATRIX_DIM - 1)) && (col_r == K_W'(MATRIX_DIM - 1));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    issue_ctl = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_data.mode == MODE_COMPUTE) begin
          row_nxt   = '0;
          col_nxt   = '0;
          k_nxt     = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        issue_ctl.valid = 1'b1;
        issue_ctl.first = (k_r == '0);
        issue_ctl.last  = (k_r == K_W'(MATRIX_DIM - 1));
        if (issue_ctl.last) begin
          state_nxt = ST_WAIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (mac_res_valid) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          k_nxt    = '0;
          if (elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            if (col_r == K_W'(MATRIX_DIM - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      frac_r      <= FRAC_RESET;
      out_valid_r <= 1'b0;
      op_ctl_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      op_ctl_r    <= issue_ctl;
      if (cfg_wr_en) begin
        frac_r <= cfg_wr_data;
      end
    end
  end

  // Operand stores: cleared at reset, one element per write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NELEM; e++) begin
        a_store_r[e] <= '0;
        b_store_r[e] <= '0;
      end
    end else if (in_xfer && wr_ok) begin
      if (in_data.mode == MODE_WR_A) begin
        a_store_r[ELEM_W'(in_data.element_index)] <= in_data.element_value;
      end else if (in_data.mode == MODE_WR_B) begin
        b_store_r[ELEM_W'(in_data.element_index)] <= in_data.element_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_a_r <= a_store_r[a_addr];
    op_b_r <= b_store_r[b_addr];
    if (out_load) begin
      out_data_r.result_index <= IDX_W'(out_pos);
      out_data_r.result_value <= mac_res.value;
      out_data_r.saturated    <= mac_res.saturated;
      out_data_r.last         <= elem_last;
    end
  end

  mm4_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (op_ctl_r),
    .op_a      (op_a_r),
    .op_b      (op_b_r),
    .frac_bits (frac_r),
    .res       (mac_res),
    .res_valid (mac_res_valid)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("output valid rose outside the output state");

  a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res_valid |-> state_r == ST_WAIT)
    else $error("MAC result arrived while not waiting for it");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last |-> out_data_r.result_index == IDX_W'(NELEM - 1))
    else $error("last flag on an element other than the final one");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && state_nxt == ST_IDLE |-> elem_last && out_load)
    else $error("compute finished before the final element was loaded");

endmodule

`default_nettype wire
